// File: sv/ebalu_pkg.sv
// Package for the 8-bit CPU ALU: word layouts, operation codes and constants.
// No dependencies; used by ebalu_core and eight_bit_cpu_alu_flags.
package ebalu_pkg;

  localparam int REQ_BYTES = 9;
  localparam int RESP_BYTES = 4;

  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_ADC   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_SBC   = 5'd3;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_XOR   = 5'd5;
  localparam logic [4:0] OP_OR    = 5'd6;
  localparam logic [4:0] OP_CP    = 5'd7;
  localparam logic [4:0] OP_INC   = 5'd8;
  localparam logic [4:0] OP_DEC   = 5'd9;
  localparam logic [4:0] OP_CPL   = 5'd10;
  localparam logic [4:0] OP_DAA   = 5'd11;
  localparam logic [4:0] OP_RLC   = 5'd12;
  localparam logic [4:0] OP_RRC   = 5'd13;
  localparam logic [4:0] OP_RL    = 5'd14;
  localparam logic [4:0] OP_RR    = 5'd15;
  localparam logic [4:0] OP_SLA   = 5'd16;
  localparam logic [4:0] OP_SRA   = 5'd17;
  localparam logic [4:0] OP_SRL   = 5'd18;
  localparam logic [4:0] OP_SWAP  = 5'd19;
  localparam logic [4:0] OP_BIT   = 5'd20;
  localparam logic [4:0] OP_SET   = 5'd21;
  localparam logic [4:0] OP_RES   = 5'd22;
  localparam logic [4:0] OP_RLCA  = 5'd23;
  localparam logic [4:0] OP_RRCA  = 5'd24;
  localparam logic [4:0] OP_RLA   = 5'd25;
  localparam logic [4:0] OP_RRA   = 5'd26;
  localparam logic [4:0] OP_ADD16 = 5'd27;
  localparam logic [4:0] OP_INC16 = 5'd28;
  localparam logic [4:0] OP_DEC16 = 5'd29;
  localparam logic [4:0] OP_ADDSP = 5'd30;

  localparam logic [4:0] COST_SHORT = 5'd4;
  localparam logic [4:0] COST_MID   = 5'd8;
  localparam logic [4:0] COST_LONG  = 5'd16;

  localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
  localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
  localparam logic [7:0] DAA_LIMIT    = 8'h99;
  localparam logic [3:0] BCD_MAX      = 4'h9;

  typedef struct packed {
    logic signed [7:0] offset;
    logic [15:0]       wide_right;
    logic [15:0]       wide_left;
    logic [2:0]        bit_index;
    logic [7:0]        operand;
    logic [3:0]        flags_in;
    logic [7:0]        acc;
    logic [4:0]        req_type;
  } ebalu_req_t;

  typedef struct packed {
    logic [4:0]  cycle_cost;
    logic [3:0]  flags_out;
    logic [15:0] result;
  } ebalu_resp_t;

endpackage

// File: sv/ebalu_core.sv
// Combinational datapath of the 8-bit CPU ALU: value, flags and cycle cost.
// Depends on ebalu_pkg for the word structs, operation codes and constants.
module ebalu_core
  import ebalu_pkg::*;
(
  input  ebalu_req_t  req,
  output ebalu_resp_t resp
);

  logic [7:0]  a;
  logic [7:0]  v;
  logic [15:0] wl;
  logic [15:0] wr;
  logic        zin;
  logic        nin;
  logic        hin;
  logic        cin;
  logic        t;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  diff9;
  logic [4:0]  hdiff5;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic        daa_hi;
  logic [7:0]  daa_add1;
  logic [7:0]  daa_add;
  logic [7:0]  daa_sub1;
  logic [7:0]  daa_sub;
  logic [7:0]  daa_val;
  logic [7:0]  mask;
  logic [16:0] add17;
  logic [12:0] add13;
  logic [15:0] sp_sum;
  logic [4:0]  sp_h5;
  logic [8:0]  sp_c9;
  logic [7:0]  x;

  assign a   = req.acc;
  assign v   = req.operand;
  assign wl  = req.wide_left;
  assign wr  = req.wide_right;
  assign zin = req.flags_in[3];
  assign nin = req.flags_in[2];
  assign hin = req.flags_in[1];
  assign cin = req.flags_in[0];
  assign t   = cin & ((req.req_type == OP_ADC) || (req.req_type == OP_SBC));

  assign sum9   = {1'b0, a} + {1'b0, v} + {8'b0, t};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'b0, t};
  assign diff9  = {1'b0, a} - {1'b0, v} - {8'b0, t};
  assign hdiff5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'b0, t};
  assign inc8   = v + 8'd1;
  assign dec8   = v - 8'd1;

  assign daa_hi   = cin || (a > DAA_LIMIT);
  assign daa_add1 = daa_hi ? a + DAA_HIGH_ADJ : a;
  assign daa_add  = (hin || (a[3:0] > BCD_MAX)) ? daa_add1 + DAA_LOW_ADJ : daa_add1;
  assign daa_sub1 = hin ? a - DAA_LOW_ADJ : a;
  assign daa_sub  = cin ? daa_sub1 - DAA_HIGH_ADJ : daa_sub1;
  assign daa_val  = nin ? daa_sub : daa_add;

  assign mask   = 8'd1 << req.bit_index;
  assign add17  = {1'b0, wl} + {1'b0, wr};
  assign add13  = {1'b0, wl[11:0]} + {1'b0, wr[11:0]};
  assign sp_sum = wl + {{8{req.offset[7]}}, req.offset};
  assign sp_h5  = {1'b0, wl[3:0]} + {1'b0, req.offset[3:0]};
  assign sp_c9  = {1'b0, wl[7:0]} + {1'b0, req.offset};

  always_comb begin
    x = a;
    resp.result     = {8'h00, a};
    resp.flags_out  = req.flags_in;
    resp.cycle_cost = COST_SHORT;
    unique case (req.req_type) inside
      OP_ADD, OP_ADC: begin
        x = sum9[7:0];
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 1'b0, hsum5[4], sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        x = diff9[7:0];
        resp.result = (req.req_type == OP_CP) ? {8'h00, a} : {8'h00, x};
        resp.flags_out = {x == 8'h00, 1'b1, hdiff5[4], diff9[8]};
      end
      OP_AND: begin
        x = a & v;
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        x = a ^ v;
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 3'b000};
      end
      OP_OR: begin
        x = a | v;
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 3'b000};
      end
      OP_INC: begin
        x = inc8;
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 1'b0, x[3:0] == 4'h0, cin};
      end
      OP_DEC: begin
        x = dec8;
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 1'b1, x[3:0] == 4'hF, cin};
      end
      OP_CPL: begin
        x = ~a;
        resp.result = {8'h00, x};
        resp.flags_out = {zin, 1'b1, 1'b1, cin};
      end
      OP_DAA: begin
        x = daa_val;
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, nin, 1'b0, nin ? cin : daa_hi};
      end
      OP_RLC: begin
        x = {v[6:0], v[7]};
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 2'b00, v[7]};
        resp.cycle_cost = COST_MID;
      end
      OP_RRC: begin
        x = {v[0], v[7:1]};
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 2'b00, v[0]};
        resp.cycle_cost = COST_MID;
      end
      OP_RL: begin
        x = {v[6:0], cin};
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 2'b00, v[7]};
        resp.cycle_cost = COST_MID;
      end
      OP_RR: begin
        x = {cin, v[7:1]};
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 2'b00, v[0]};
        resp.cycle_cost = COST_MID;
      end
      OP_SLA: begin
        x = {v[6:0], 1'b0};
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 2'b00, v[7]};
        resp.cycle_cost = COST_MID;
      end
      OP_SRA: begin
        x = {v[7], v[7:1]};
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 2'b00, v[0]};
        resp.cycle_cost = COST_MID;
      end
      OP_SRL: begin
        x = {1'b0, v[7:1]};
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 2'b00, v[0]};
        resp.cycle_cost = COST_MID;
      end
      OP_SWAP: begin
        x = {v[3:0], v[7:4]};
        resp.result = {8'h00, x};
        resp.flags_out = {x == 8'h00, 3'b000};
        resp.cycle_cost = COST_MID;
      end
      OP_BIT: begin
        resp.flags_out = {(v & mask) == 8'h00, 1'b0, 1'b1, cin};
        resp.cycle_cost = COST_MID;
      end
      OP_SET: begin
        x = v | mask;
        resp.result = {8'h00, x};
        resp.cycle_cost = COST_MID;
      end
      OP_RES: begin
        x = v & ~mask;
        resp.result = {8'h00, x};
        resp.cycle_cost = COST_MID;
      end
      OP_RLCA: begin
        x = {a[6:0], a[7]};
        resp.result = {8'h00, x};
        resp.flags_out = {3'b000, a[7]};
      end
      OP_RRCA: begin
        x = {a[0], a[7:1]};
        resp.result = {8'h00, x};
        resp.flags_out = {3'b000, a[0]};
      end
      OP_RLA: begin
        x = {a[6:0], cin};
        resp.result = {8'h00, x};
        resp.flags_out = {3'b000, a[7]};
      end
      OP_RRA: begin
        x = {cin, a[7:1]};
        resp.result = {8'h00, x};
        resp.flags_out = {3'b000, a[0]};
      end
      OP_ADD16: begin
        resp.result = add17[15:0];
        resp.flags_out = {zin, 1'b0, add13[12], add17[16]};
        resp.cycle_cost = COST_MID;
      end
      OP_INC16: begin
        resp.result = wl + 16'd1;
        resp.cycle_cost = COST_MID;
      end
      OP_DEC16: begin
        resp.result = wl - 16'd1;
        resp.cycle_cost = COST_MID;
      end
      OP_ADDSP: begin
        resp.result = sp_sum;
        resp.flags_out = {2'b00, sp_h5[4], sp_c9[8]};
        resp.cycle_cost = COST_LONG;
      end
      default: begin
        resp.result = {8'h00, a};
      end
    endcase
  end

endmodule

// File: sv/eight_bit_cpu_alu_flags.sv
// Top level of the 8-bit CPU ALU: stream ports, input register, result register.
// Depends on ebalu_pkg and ebalu_core.
//
// Each input word carries one ALU operation and returns one result word with
// the new value, the new Z/N/H/C flags and the operation's cycle cost. The
// block takes one word per clock unless output back-pressure stalls it. A word
// is registered at acceptance. The ALU datapath computes it from the input
// register, and the result register loads it when the output can advance;
// output tvalid rises with that load. The input register keeps accepting
// while a result waits. Back-pressure on the output only stalls the input
// once both registers hold words.
module eight_bit_cpu_alu_flags
  import ebalu_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // req_type[4:0], acc[12:5], flags_in[16:13], operand[24:17], bit_index[27:25],
  // wide_left[43:28], wide_right[59:44], offset[67:60], zero[71:68]
  input  logic [REQ_BYTES*8-1:0]    s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // result[15:0], flags_out[19:16], cycle_cost[24:20], zero[31:25]
  output logic [RESP_BYTES*8-1:0]   m_axis_tdata
);

  localparam int ReqW  = $bits(ebalu_req_t);
  localparam int RespW = $bits(ebalu_resp_t);

  logic        stage_valid;
  ebalu_req_t  stage_req;
  logic        out_valid;
  ebalu_resp_t out_resp;
  ebalu_resp_t core_resp;
  logic        advance;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !stage_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(RESP_BYTES*8-RespW){1'b0}}, out_resp};

  ebalu_core u_core (
    .req  (stage_req),
    .resp (core_resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        stage_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stage_req <= ebalu_req_t'(s_axis_tdata[ReqW-1:0]);
    end
    if (advance && stage_valid) begin
      out_resp <= core_resp;
    end
  end

endmodule

// File: tb/sv/alu_outcome_checker.sv
`timescale 1ns / 1ps
// Checker for eight_bit_cpu_alu_flags: predicts value, flags and cost for each accepted
// input word and compares them in order with the output words. Depends on ebalu_pkg.
module alu_outcome_checker
  import ebalu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_valid,
  input  logic                    s_ready,
  input  logic [REQ_BYTES*8-1:0]  s_data,
  input  logic                    m_valid,
  input  logic                    m_ready,
  input  logic [RESP_BYTES*8-1:0] m_data,
  output int                      mismatches,
  output int                      outstanding,
  output int                      checked
);

  localparam int PRINT_CAP = 100;

  ebalu_resp_t outcomes_due[$];

  function automatic ebalu_resp_t alu_outcome(ebalu_req_t w);
    logic [7:0]  a;
    logic [7:0]  v;
    logic [7:0]  src;
    logic [7:0]  r8;
    logic [15:0] r16;
    logic [8:0]  sum9;
    logic [4:0]  sum5;
    logic [12:0] sum13;
    logic [16:0] sum17;
    logic        z, n, h, c, t, wide;
    ebalu_resp_t o;
    a = w.acc;
    v = w.operand;
    {z, n, h, c} = w.flags_in;
    r8 = a;
    r16 = '0;
    src = v;
    wide = 1'b0;
    o.cycle_cost = COST_SHORT;
    case (w.req_type)
      OP_ADD, OP_ADC: begin
        t = (w.req_type == OP_ADC) & c;
        sum9 = {1'b0, a} + {1'b0, v} + {8'd0, t};
        sum5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, t};
        r8 = sum9[7:0];
        z = (r8 == 8'h00); n = 1'b0; h = sum5[4]; c = sum9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        t = (w.req_type == OP_SBC) & c;
        sum9 = {1'b0, a} - {1'b0, v} - {8'd0, t};
        sum5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, t};
        r8 = (w.req_type == OP_CP) ? a : sum9[7:0];
        z = (sum9[7:0] == 8'h00); n = 1'b1; h = sum5[4]; c = sum9[8];
      end
      OP_AND: begin
        r8 = a & v;
        z = (r8 == 8'h00); n = 1'b0; h = 1'b1; c = 1'b0;
      end
      OP_XOR, OP_OR: begin
        r8 = (w.req_type == OP_XOR) ? (a ^ v) : (a | v);
        z = (r8 == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_INC: begin
        r8 = v + 8'd1;
        z = (r8 == 8'h00); n = 1'b0; h = (r8[3:0] == 4'h0);
      end
      OP_DEC: begin
        r8 = v - 8'd1;
        z = (r8 == 8'h00); n = 1'b1; h = (r8[3:0] == 4'hF);
      end
      OP_CPL: begin
        r8 = ~a;
        n = 1'b1; h = 1'b1;
      end
      OP_DAA: begin
        if (n) begin
          if (h) r8 = r8 - DAA_LOW_ADJ;
          if (c) r8 = r8 - DAA_HIGH_ADJ;
        end else begin
          if (c || a > DAA_LIMIT) begin
            r8 = r8 + DAA_HIGH_ADJ;
            c = 1'b1;
          end
          if (h || a[3:0] > BCD_MAX) r8 = r8 + DAA_LOW_ADJ;
        end
        z = (r8 == 8'h00); h = 1'b0;
      end
      OP_RLC, OP_RLCA: begin
        src = (w.req_type == OP_RLCA) ? a : v;
        r8 = {src[6:0], src[7]};
        c = src[7];
        z = (w.req_type == OP_RLC) && (r8 == 8'h00); n = 1'b0; h = 1'b0;
        o.cycle_cost = (w.req_type == OP_RLC) ? COST_MID : COST_SHORT;
      end
      OP_RRC, OP_RRCA: begin
        src = (w.req_type == OP_RRCA) ? a : v;
        r8 = {src[0], src[7:1]};
        c = src[0];
        z = (w.req_type == OP_RRC) && (r8 == 8'h00); n = 1'b0; h = 1'b0;
        o.cycle_cost = (w.req_type == OP_RRC) ? COST_MID : COST_SHORT;
      end
      OP_RL, OP_RLA: begin
        src = (w.req_type == OP_RLA) ? a : v;
        r8 = {src[6:0], c};
        c = src[7];
        z = (w.req_type == OP_RL) && (r8 == 8'h00); n = 1'b0; h = 1'b0;
        o.cycle_cost = (w.req_type == OP_RL) ? COST_MID : COST_SHORT;
      end
      OP_RR, OP_RRA: begin
        src = (w.req_type == OP_RRA) ? a : v;
        r8 = {c, src[7:1]};
        c = src[0];
        z = (w.req_type == OP_RR) && (r8 == 8'h00); n = 1'b0; h = 1'b0;
        o.cycle_cost = (w.req_type == OP_RR) ? COST_MID : COST_SHORT;
      end
      OP_SLA, OP_SRA, OP_SRL, OP_SWAP: begin
        case (w.req_type)
          OP_SLA:  begin r8 = {v[6:0], 1'b0}; c = v[7]; end
          OP_SRA:  begin r8 = {v[7], v[7:1]}; c = v[0]; end
          OP_SRL:  begin r8 = {1'b0, v[7:1]}; c = v[0]; end
          default: begin r8 = {v[3:0], v[7:4]}; c = 1'b0; end
        endcase
        z = (r8 == 8'h00); n = 1'b0; h = 1'b0;
        o.cycle_cost = COST_MID;
      end
      OP_BIT: begin
        z = !v[w.bit_index]; n = 1'b0; h = 1'b1;
        o.cycle_cost = COST_MID;
      end
      OP_SET: begin
        r8 = v | (8'h01 << w.bit_index);
        o.cycle_cost = COST_MID;
      end
      OP_RES: begin
        r8 = v & ~(8'h01 << w.bit_index);
        o.cycle_cost = COST_MID;
      end
      OP_ADD16: begin
        sum17 = {1'b0, w.wide_left} + {1'b0, w.wide_right};
        sum13 = {1'b0, w.wide_left[11:0]} + {1'b0, w.wide_right[11:0]};
        r16 = sum17[15:0]; wide = 1'b1;
        n = 1'b0; h = sum13[12]; c = sum17[16];
        o.cycle_cost = COST_MID;
      end
      OP_INC16, OP_DEC16: begin
        r16 = (w.req_type == OP_INC16) ? w.wide_left + 16'd1 : w.wide_left - 16'd1;
        wide = 1'b1;
        o.cycle_cost = COST_MID;
      end
      OP_ADDSP: begin
        r16 = w.wide_left + {{8{w.offset[7]}}, w.offset};
        sum5 = {1'b0, w.wide_left[3:0]} + {1'b0, w.offset[3:0]};
        sum9 = {1'b0, w.wide_left[7:0]} + {1'b0, w.offset};
        wide = 1'b1;
        z = 1'b0; n = 1'b0; h = sum5[4]; c = sum9[8];
        o.cycle_cost = COST_LONG;
      end
      default: ;
    endcase
    o.result = wide ? r16 : {8'h00, r8};
    o.flags_out = {z, n, h, c};
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
               checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    ebalu_req_t  word_in;
    ebalu_resp_t got;
    ebalu_resp_t want;
    if (!rst) begin
      if (s_valid && s_ready) begin
        word_in = ebalu_req_t'(s_data[$bits(ebalu_req_t)-1:0]);
        outcomes_due.push_back(alu_outcome(word_in));
      end
      if (m_valid && m_ready) begin
        got = ebalu_resp_t'(m_data[$bits(ebalu_resp_t)-1:0]);
        if (outcomes_due.size() == 0) begin
          report_mismatch("word with nothing pending", m_data, 0);
        end else begin
          want = outcomes_due.pop_front();
          if (got.result !== want.result)
            report_mismatch("result", 32'(got.result), 32'(want.result));
          if (got.flags_out !== want.flags_out)
            report_mismatch("flags", 32'(got.flags_out), 32'(want.flags_out));
          if (got.cycle_cost !== want.cycle_cost)
            report_mismatch("cycle cost", 32'(got.cycle_cost), 32'(want.cycle_cost));
          if (m_data[RESP_BYTES*8-1:$bits(ebalu_resp_t)] !== '0)
            report_mismatch("padding",
                            32'(m_data[RESP_BYTES*8-1:$bits(ebalu_resp_t)]), 0);
        end
        checked++;
      end
      outstanding = outcomes_due.size();
    end
  end

endmodule

// File: tb/sv/eight_bit_cpu_alu_flags_tb.sv
`timescale 1ns / 1ps
// Testbench top for eight_bit_cpu_alu_flags: directed and random ALU words with random
// source and sink gaps. Depends on ebalu_pkg, the block and alu_outcome_checker.
module eight_bit_cpu_alu_flags_tb;
  import ebalu_pkg::*;

  localparam logic [4:0] OP_UNUSED = 5'd31;
  localparam int RANDOM_OPS  = 1450;
  localparam int BURST_SPAN  = 120;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 8;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [REQ_BYTES*8-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [RESP_BYTES*8-1:0] m_axis_tdata;
  int                      mismatches;
  int                      outstanding;
  int                      checked;
  int                      sent = 0;
  int                      cycles = 0;

  always #10 clk = ~clk;

  eight_bit_cpu_alu_flags dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  alu_outcome_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .s_data      (s_axis_tdata),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .m_data      (m_axis_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      4:       return 8'h0F;
      5:       return 8'h99;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_wide();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0FFF;
      3:       return 16'h00FF;
      4:       return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic drive_op(input ebalu_req_t w);
    int gap;
    gap = ((sent / BURST_SPAN) % 3 == 2) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(REQ_BYTES*8-$bits(ebalu_req_t)){1'b0}}, w};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic drive_fields(input logic [4:0] op, input logic [7:0] a, input logic [3:0] f,
                              input logic [7:0] v, input logic [2:0] idx,
                              input logic [15:0] wl, input logic [15:0] wr,
                              input logic [7:0] off);
    ebalu_req_t w;
    w.req_type = op;
    w.acc = a;
    w.flags_in = f;
    w.operand = v;
    w.bit_index = idx;
    w.wide_left = wl;
    w.wide_right = wr;
    w.offset = off;
    drive_op(w);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("eight_bit_cpu_alu_flags verification failed");
      $finish;
    end
  end

  initial begin
    int stall;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      stall = ((taken / BURST_SPAN) % 3 == 1) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin
    ebalu_req_t w;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    drive_fields(OP_ADD,   8'hFF, 4'b0000, 8'h01, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_ADC,   8'h0F, 4'b0001, 8'h00, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_SUB,   8'h00, 4'b0000, 8'h01, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_SBC,   8'h00, 4'b0001, 8'h00, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_SBC,   8'h10, 4'b0001, 8'h0F, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_AND,   8'hFF, 4'b1111, 8'h00, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_XOR,   8'h5A, 4'b1111, 8'h5A, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_OR,    8'h80, 4'b0000, 8'h01, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_CP,    8'h3C, 4'b0000, 8'h3C, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_INC,   8'h00, 4'b0001, 8'hFF, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_DEC,   8'h00, 4'b0000, 8'h10, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_CPL,   8'h00, 4'b1001, 8'h00, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_DAA,   8'h9A, 4'b0000, 8'h00, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_DAA,   8'h00, 4'b0111, 8'h00, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_RLC,   8'h00, 4'b0000, 8'h80, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_RRC,   8'h00, 4'b0000, 8'h01, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_RL,    8'h00, 4'b0000, 8'h80, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_RR,    8'h00, 4'b0001, 8'h01, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_SLA,   8'h00, 4'b0000, 8'h80, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_SRA,   8'h00, 4'b0000, 8'h81, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_SRL,   8'h00, 4'b0000, 8'h01, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_SWAP,  8'h00, 4'b0001, 8'hF0, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_BIT,   8'h55, 4'b0001, 8'h7F, 3'd7, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_BIT,   8'hAA, 4'b1000, 8'h01, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_SET,   8'h00, 4'b1010, 8'h00, 3'd7, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_RES,   8'h00, 4'b0101, 8'hFF, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_RLCA,  8'h80, 4'b1000, 8'h00, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_RRCA,  8'h01, 4'b1000, 8'h00, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_RLA,   8'h80, 4'b0000, 8'h00, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_RRA,   8'h01, 4'b0001, 8'h00, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_ADD16, 8'h00, 4'b1000, 8'h00, 3'd0, 16'hFFFF, 16'h0001, 8'h00);
    drive_fields(OP_ADD16, 8'h00, 4'b0000, 8'h00, 3'd0, 16'h0FFF, 16'h0001, 8'h00);
    drive_fields(OP_INC16, 8'h00, 4'b1111, 8'h00, 3'd0, 16'hFFFF, 16'h0000, 8'h00);
    drive_fields(OP_DEC16, 8'h00, 4'b0000, 8'h00, 3'd0, 16'h0000, 16'h0000, 8'h00);
    drive_fields(OP_ADDSP, 8'h00, 4'b1111, 8'h00, 3'd0, 16'h00FF, 16'h0000, 8'h01);
    drive_fields(OP_ADDSP, 8'h00, 4'b0000, 8'h00, 3'd0, 16'h0000, 16'h0000, 8'h80);
    drive_fields(OP_UNUSED, 8'hA5, 4'b1010, 8'h3C, 3'd5, 16'h1234, 16'h5678, 8'h7F);
    drain_results();

    for (int i = 0; i < RANDOM_OPS; i++) begin
      w.req_type = 5'($urandom_range(0, 30));
      w.acc = pick_byte();
      w.flags_in = 4'($urandom_range(0, 15));
      w.operand = pick_byte();
      w.bit_index = 3'($urandom_range(0, 7));
      w.wide_left = pick_wide();
      w.wide_right = pick_wide();
      w.offset = pick_byte();
      drive_op(w);
      if (i == RANDOM_OPS / 2) drain_results();
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d ALU words over every opcode, %0d results checked, with random gaps",
             sent, checked);
    $display("on both sides and directed carry, borrow, decimal-adjust and bit-test corners.");
    if (mismatches == 0) begin
      $display("eight_bit_cpu_alu_flags verification clean");
    end else begin
      $display("eight_bit_cpu_alu_flags verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ebalu_pkg.sv
sv/ebalu_core.sv
sv/eight_bit_cpu_alu_flags.sv
tb/sv/alu_outcome_checker.sv
tb/sv/eight_bit_cpu_alu_flags_tb.sv
